// ----- rtl/cba_pkg.sv -----
// Package for the contiguous block allocator: sizes, status codes, queue entry type.
`default_nettype none
package cba_pkg;
    localparam int NUM_BLOCKS  = 16;
    localparam int BLOCK_BYTES = 64;
    localparam int BLK_W       = $clog2(NUM_BLOCKS);
    localparam int CNT_W       = BLK_W + 1;
    localparam int SHIFT       = $clog2(BLOCK_BYTES);
    localparam int CAP_BYTES   = (NUM_BLOCKS * BLOCK_BYTES > 1024) ? 1024
                                 : NUM_BLOCKS * BLOCK_BYTES;
    localparam int BYTES_W     = 11;
    localparam int OFF_W       = 10;
    localparam int ST_W        = 3;

    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_SIZE   = 3'd1;
    localparam logic [ST_W-1:0] ST_ABOVE_POOL = 3'd2;
    localparam logic [ST_W-1:0] ST_ABOVE_FREE = 3'd3;
    localparam logic [ST_W-1:0] ST_NO_RUN     = 3'd4;
    localparam logic [ST_W-1:0] ST_NO_RECORD  = 3'd5;
    localparam logic [ST_W-1:0] ST_NOT_FOUND  = 3'd6;

    // classified request passed from front to back
    typedef struct packed {
        logic               is_free;
        logic [BYTES_W-1:0] bytes;
        logic [CNT_W-1:0]   need;
        logic [OFF_W-1:0]   offset;
        logic               off_ok;   // offset is block aligned and in range
        logic [BLK_W-1:0]   off_blk;
    } t_cmd;
endpackage
`default_nettype wire

// ----- rtl/cba_front.sv -----
// Front end: accepts requests and precomputes block count and offset decode.
`default_nettype none
module cba_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    output logic                         o_full,
    input  wire logic                    i_action,
    input  wire logic [10:0]             i_request_bytes,
    input  wire logic [9:0]              i_free_offset,
    output logic                         o_valid,
    input  wire logic                    i_take,
    output cba_pkg::t_cmd                o_cmd
);
    logic [1:0]          r_cnt, n_cnt;
    cba_pkg::t_cmd       r_q [2];
    logic                r_wp, r_rp;
    cba_pkg::t_cmd       w_c;
    logic                w_push, w_pop;
    logic [11:0]         w_sum;

    // decode the beat
    always_comb begin
        w_sum         = {1'b0, i_request_bytes} + 12'(cba_pkg::BLOCK_BYTES - 1);
        w_c.is_free   = i_action;
        w_c.bytes     = i_request_bytes;
        w_c.need      = (w_sum >> cba_pkg::SHIFT) > 12'(cba_pkg::NUM_BLOCKS)
                        ? cba_pkg::CNT_W'(cba_pkg::NUM_BLOCKS)
                        : cba_pkg::CNT_W'(w_sum >> cba_pkg::SHIFT);
        w_c.offset    = i_free_offset;
        w_c.off_ok    = (i_free_offset[cba_pkg::SHIFT-1:0] == '0) &&
                        ((i_free_offset >> cba_pkg::SHIFT) < 10'(cba_pkg::NUM_BLOCKS));
        w_c.off_blk   = cba_pkg::BLK_W'(i_free_offset >> cba_pkg::SHIFT);
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    always_comb begin
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    // two-entry queue between front and back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
        end
        if (w_push) r_q[r_wp] <= w_c;
    end
endmodule
`default_nettype wire

// ----- rtl/cba_back.sv -----
// Back end: sequencer that scans block marks and records, one entry per cycle.
`default_nettype none
module cba_back (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [10:0]             i_pool_bytes,
    input  wire logic                    i_valid,
    output logic                         o_take,
    input  wire cba_pkg::t_cmd           i_cmd,
    output logic                         o_empty,
    input  wire logic                    i_pop,
    output logic [2:0]                   o_status
);
    localparam logic [2:0] S_IDLE = 3'd0, S_CHK = 3'd1, S_RUN = 3'd2,
                           S_SLOT = 3'd3, S_MARK = 3'd4, S_FIND = 3'd5,
                           S_CLR = 3'd6, S_DONE = 3'd7;
    localparam int NB = cba_pkg::NUM_BLOCKS;
    localparam int BW = cba_pkg::BLK_W;
    localparam int CW = cba_pkg::CNT_W;

    logic [2:0]          r_st;
    cba_pkg::t_cmd       r_cmd;
    logic [NB-1:0]       r_busy, r_rv;
    logic [BW-1:0]       r_rs [NB];
    logic [CW-1:0]       r_rb [NB];
    logic [10:0]         r_rbytes [NB];
    logic [10:0]         r_used;
    logic [CW-1:0]       r_i, r_run, r_nblk;
    logic [BW-1:0]       r_start;
    logic [CW-1:0]       r_left;
    logic [BW-1:0]       r_slot;
    logic [2:0]          r_res;
    logic                r_have;
    logic [10:0]         w_pool, w_freeb;
    logic [11:0]         w_nb;
    logic [BW-1:0]       w_i;

    assign w_i      = r_i[BW-1:0];
    assign w_pool   = (i_pool_bytes > 11'(cba_pkg::CAP_BYTES))
                      ? 11'(cba_pkg::CAP_BYTES) : i_pool_bytes;
    assign w_freeb  = (r_used >= w_pool) ? 11'd0 : w_pool - r_used;
    assign w_nb     = ({1'b0, w_pool} + 12'(cba_pkg::BLOCK_BYTES - 1)) >> cba_pkg::SHIFT;
    assign o_take   = (r_st == S_IDLE) && i_valid && !r_have;
    assign o_empty  = !r_have;
    assign o_status = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_busy <= '0;
            r_rv   <= '0;
            r_used <= '0;
            r_have <= 1'b0;
        end else begin
            if (i_pop && r_have) r_have <= 1'b0;
            case (r_st)
                S_IDLE: if (o_take) begin
                    r_cmd <= i_cmd;
                    r_i   <= '0;
                    r_run <= '0;
                    r_st  <= i_cmd.is_free ? S_FIND : S_CHK;
                end
                // size checks
                S_CHK: begin
                    r_nblk <= CW'(w_nb);
                    if (r_cmd.bytes == '0) begin
                        r_res <= cba_pkg::ST_BAD_SIZE;
                        r_st  <= S_DONE;
                    end else if (r_cmd.bytes > w_pool) begin
                        r_res <= cba_pkg::ST_ABOVE_POOL;
                        r_st  <= S_DONE;
                    end else if (r_cmd.bytes > w_freeb) begin
                        r_res <= cba_pkg::ST_ABOVE_FREE;
                        r_st  <= S_DONE;
                    end else r_st <= S_RUN;
                end
                // first-fit scan, one block a cycle
                S_RUN: begin
                    if (r_i >= r_nblk) begin
                        r_res <= cba_pkg::ST_NO_RUN;
                        r_st  <= S_DONE;
                    end else if (r_busy[w_i]) begin
                        r_run <= '0;
                        r_i   <= r_i + 1'b1;
                    end else begin
                        if (r_run == '0) r_start <= w_i;
                        r_run <= r_run + 1'b1;
                        if (r_run + 1'b1 == r_cmd.need) begin
                            r_i  <= '0;
                            r_st <= S_SLOT;
                        end else r_i <= r_i + 1'b1;
                    end
                end
                // lowest free record slot
                S_SLOT: begin
                    if (r_i == CW'(NB)) begin
                        r_res <= cba_pkg::ST_NO_RECORD;
                        r_st  <= S_DONE;
                    end else if (!r_rv[w_i]) begin
                        r_rv[w_i]     <= 1'b1;
                        r_rs[w_i]     <= r_start;
                        r_rb[w_i]     <= r_cmd.need;
                        r_rbytes[w_i] <= r_cmd.bytes;
                        r_used        <= r_used + r_cmd.bytes;
                        r_left        <= r_cmd.need;
                        r_i           <= CW'(r_start);
                        r_res         <= cba_pkg::ST_OK;
                        r_st          <= S_MARK;
                    end else r_i <= r_i + 1'b1;
                end
                S_MARK: begin
                    if (r_left == '0 || r_i >= CW'(NB)) r_st <= S_DONE;
                    else begin
                        r_busy[w_i] <= 1'b1;
                        r_i  <= r_i + 1'b1;
                        r_left <= r_left - 1'b1;
                    end
                end
                // record search for free
                S_FIND: begin
                    if (r_i == CW'(NB) || !r_cmd.off_ok) begin
                        r_res <= cba_pkg::ST_NOT_FOUND;
                        r_st  <= S_DONE;
                    end else if (r_rv[w_i] && r_rs[w_i] == r_cmd.off_blk) begin
                        r_rv[w_i] <= 1'b0;
                        r_used <= (r_used >= r_rbytes[w_i]) ? r_used - r_rbytes[w_i] : '0;
                        r_left <= r_rb[w_i];
                        r_i    <= CW'(r_rs[w_i]);
                        r_res  <= cba_pkg::ST_OK;
                        r_st   <= S_CLR;
                    end else r_i <= r_i + 1'b1;
                end
                S_CLR: begin
                    if (r_left == '0 || r_i >= CW'(NB)) r_st <= S_DONE;
                    else begin
                        r_busy[w_i] <= 1'b0;
                        r_i  <= r_i + 1'b1;
                        r_left <= r_left - 1'b1;
                    end
                end
                S_DONE: begin
                    r_have <= 1'b1;
                    r_st   <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/contiguous_block_allocator.sv -----
// Top level of the first-fit contiguous block allocator.
//  channel | ports                                        | dir
//  request | push full i_action i_request_bytes i_free_offset | in
//  result  | empty pop o_status                           | out
//  config  | i_cfg_we i_cfg_data (pool_bytes)             | in
// A result is produced by the back-end sequencer, which walks block marks and record
// slots one entry per cycle.
// Reset is synchronous, active low; marks, valid bits and byte count clear at once.
// A two-entry queue lets requests arrive while the back end is busy; the back end
// waits while its one result beat is not popped and takes the next in the cycle after.
`default_nettype none
module contiguous_block_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_action,
    input  wire logic [10:0] i_request_bytes,
    input  wire logic [9:0]  i_free_offset,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       o_status,
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_data
);
    logic [10:0]   r_pool_bytes;
    logic          w_valid, w_take;
    cba_pkg::t_cmd w_cmd;

    // pool size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pool_bytes <= 11'd1024;
        else if (i_cfg_we) r_pool_bytes <= i_cfg_data;
    end

    cba_front u_front (.i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_action,
        .i_request_bytes, .i_free_offset, .o_valid(w_valid), .i_take(w_take),
        .o_cmd(w_cmd));

    cba_back u_back (.i_clk, .i_rst_n, .i_pool_bytes(r_pool_bytes),
        .i_valid(w_valid), .o_take(w_take), .i_cmd(w_cmd), .o_empty(empty),
        .i_pop(pop), .o_status);
endmodule
`default_nettype wire

// ----- rtl/cba_checker.sv -----
// Port-level checker for the allocator, bound to the top level.
`default_nettype none
module cba_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [2:0] o_status
);
    a_st_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_status != 3'd7) else $error("bad status");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_status)) else $error("result lost");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("reset state");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop |=> empty) else $error("result repeated");
endmodule
bind contiguous_block_allocator cba_checker u_chk (.i_clk, .i_rst_n, .full, .empty,
    .pop, .o_status);
`default_nettype wire

// ----- tb/contiguous_block_allocator_chk.sv -----
// Checker for the contiguous block allocator: predicts each request's status and compares.
`timescale 1ns / 100ps
`default_nettype none
module contiguous_block_allocator_chk (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic        i_action,
    input  wire logic [10:0] i_request_bytes,
    input  wire logic [9:0]  i_free_offset,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [2:0]  o_status,
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_status_seen [0:7]
);
    // shadow allocator state
    bit        busy_map  [cba_pkg::NUM_BLOCKS];
    bit        slot_used [cba_pkg::NUM_BLOCKS];
    int        slot_start[cba_pkg::NUM_BLOCKS];
    int        slot_blks [cba_pkg::NUM_BLOCKS];
    int        slot_bytes[cba_pkg::NUM_BLOCKS];
    int        used_bytes;
    int        pool_cfg;
    logic [2:0] status_q[$];

    // status of one allocate, updates shadow state
    function automatic logic [2:0] alloc_status(int size);
        int pool, freeb, nblk, need, run, start, slot;
        bit found;
        pool = pool_cfg > 1024 ? 1024 : pool_cfg;
        if (pool > cba_pkg::NUM_BLOCKS * cba_pkg::BLOCK_BYTES)
            pool = cba_pkg::NUM_BLOCKS * cba_pkg::BLOCK_BYTES;
        freeb = used_bytes >= pool ? 0 : pool - used_bytes;
        nblk = (pool + cba_pkg::BLOCK_BYTES - 1) / cba_pkg::BLOCK_BYTES;
        run = 0; start = 0; found = 0; slot = cba_pkg::NUM_BLOCKS;
        if (size == 0) return cba_pkg::ST_BAD_SIZE;
        if (size > pool) return cba_pkg::ST_ABOVE_POOL;
        if (size > freeb) return cba_pkg::ST_ABOVE_FREE;
        need = (size + cba_pkg::BLOCK_BYTES - 1) / cba_pkg::BLOCK_BYTES;
        for (int i = 0; i < nblk && i < cba_pkg::NUM_BLOCKS; i++) begin
            if (busy_map[i]) begin
                run = 0;
                continue;
            end
            if (run == 0) start = i;
            run++;
            if (run == need) begin
                found = 1;
                break;
            end
        end
        if (!found) return cba_pkg::ST_NO_RUN;
        for (int s = cba_pkg::NUM_BLOCKS - 1; s >= 0; s--)
            if (!slot_used[s]) slot = s;
        if (slot == cba_pkg::NUM_BLOCKS) return cba_pkg::ST_NO_RECORD;
        slot_used[slot]  = 1;
        slot_start[slot] = start;
        slot_blks[slot]  = need;
        slot_bytes[slot] = size;
        for (int i = start; i < start + need && i < cba_pkg::NUM_BLOCKS; i++)
            busy_map[i] = 1;
        used_bytes = (used_bytes + size) & 11'h7FF;
        return cba_pkg::ST_OK;
    endfunction

    // status of one release, updates shadow state
    function automatic logic [2:0] release_status(int offset);
        int slot;
        slot = cba_pkg::NUM_BLOCKS;
        for (int s = cba_pkg::NUM_BLOCKS - 1; s >= 0; s--)
            if (slot_used[s] && slot_start[s] * cba_pkg::BLOCK_BYTES == offset) slot = s;
        if (slot == cba_pkg::NUM_BLOCKS) return cba_pkg::ST_NOT_FOUND;
        for (int i = slot_start[slot]; i < slot_start[slot] + slot_blks[slot]
             && i < cba_pkg::NUM_BLOCKS; i++) busy_map[i] = 0;
        slot_used[slot] = 0;
        used_bytes = used_bytes >= slot_bytes[slot] ? used_bytes - slot_bytes[slot] : 0;
        return cba_pkg::ST_OK;
    endfunction

    assign o_pending = status_q.size();

    always @(posedge i_clk) begin
        logic [2:0] want;
        if (!i_rst_n) begin
            for (int i = 0; i < cba_pkg::NUM_BLOCKS; i++) begin
                busy_map[i] = 0;
                slot_used[i] = 0;
            end
            used_bytes = 0;
            pool_cfg = 1024;
            status_q.delete();
        end else begin
            if (i_cfg_we) pool_cfg = i_cfg_data;
            // request beat
            if (push && !full) begin
                if (i_action) status_q.push_back(release_status(i_free_offset));
                else status_q.push_back(alloc_status(i_request_bytes));
            end
            // result beat
            if (pop && !empty) begin
                if (status_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual status %0d",
                             $time, o_status);
                    o_fail_count++;
                end else begin
                    want = status_q.pop_front();
                    o_status_seen[o_status]++;
                    if (o_status !== want) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want, o_status);
                        o_fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        o_fail_count = 0;
        for (int i = 0; i < 8; i++) o_status_seen[i] = 0;
    end
endmodule
`default_nettype wire

// ----- tb/contiguous_block_allocator_tb.sv -----
// Testbench top for the contiguous block allocator: stimulus, config phases and verdict.
`timescale 1ns / 100ps
`default_nettype none
module contiguous_block_allocator_tb;
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        push = 0;
    logic        full;
    logic        i_action = 0;
    logic [10:0] i_request_bytes = 0;
    logic [9:0]  i_free_offset = 0;
    logic        empty;
    logic        pop = 0;
    logic [2:0]  o_status;
    logic        i_cfg_we = 0;
    logic [10:0] i_cfg_data = 0;
    int          fail_count, pending;
    int          status_seen [0:7];
    int          items_sent = 0;
    bit          pop_run = 0;

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    contiguous_block_allocator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_action(i_action), .i_request_bytes(i_request_bytes),
        .i_free_offset(i_free_offset), .empty(empty), .pop(pop),
        .o_status(o_status), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    contiguous_block_allocator_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_action(i_action), .i_request_bytes(i_request_bytes),
        .i_free_offset(i_free_offset), .empty(empty), .pop(pop),
        .o_status(o_status), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_status_seen(status_seen)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // result side: random stalls
    always @(posedge i_clk) begin
        if (pop_run) pop <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
        else pop <= 1'b0;
    end

    // one request beat, with a random gap before it; push stays high after it
    task automatic send(logic act, int bytes, int offset);
        int g;
        g = gap_len();
        if (g > 0) begin
            push <= 0;
            repeat (g) @(posedge i_clk);
        end
        push <= 1;
        i_action <= act;
        i_request_bytes <= bytes[10:0];
        i_free_offset <= offset[9:0];
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_sent++;
    endtask

    // stop sending and wait until every expected result has come
    task automatic drain();
        push <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // drain, let the back end settle, then write pool size
    task automatic set_pool(int bytes);
        drain();
        repeat (3 * cba_pkg::NUM_BLOCKS + 10) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= bytes[10:0];
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    // random mix: allocs of varied size, frees mostly aligned
    task automatic random_phase(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send(ACT_ALLOC, $urandom_range(1, 300), $urandom_range(0, 1023));
            else if (r < 50) send(ACT_ALLOC, $urandom_range(0, 2047), $urandom_range(0, 1023));
            else if (r < 90)
                send(ACT_FREE, $urandom, $urandom_range(0, 15) * cba_pkg::BLOCK_BYTES);
            else send(ACT_FREE, $urandom, $urandom_range(0, 1023));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        pop_run <= 1;
        // directed: extremes and special cases at default pool
        send(ACT_ALLOC, 0, 0);
        send(ACT_ALLOC, 2047, 1023);
        send(ACT_ALLOC, 1025, 0);
        send(ACT_ALLOC, 1, 0);
        send(ACT_ALLOC, 64, 0);
        send(ACT_ALLOC, 65, 0);
        send(ACT_ALLOC, 1024, 0);
        send(ACT_FREE, 0, 1023);
        send(ACT_FREE, 0, 64);
        send(ACT_FREE, 2047, 0);
        send(ACT_FREE, 0, 0);
        send(ACT_FREE, 0, 128);
        for (int i = 0; i < 16; i++) send(ACT_ALLOC, 1, 0);
        send(ACT_ALLOC, 1, 0);
        // sender holds until all results are back
        drain();
        send(ACT_FREE, 0, 320);
        send(ACT_FREE, 0, 384);
        send(ACT_ALLOC, 100, 0);
        send(ACT_ALLOC, 200, 0);
        random_phase(120);
        // shrink with live records, then empty, tiny and oversized pools
        set_pool(300);
        random_phase(100);
        set_pool(0);
        send(ACT_ALLOC, 1, 0);
        send(ACT_ALLOC, 0, 0);
        random_phase(30);
        set_pool(1);
        random_phase(60);
        set_pool(2047);
        random_phase(150);
        set_pool(1024);
        random_phase(120);
        drain();
        repeat (3 * cba_pkg::NUM_BLOCKS + 20) @(posedge i_clk);
        $display("sent %0d requests over pool sizes 1024, 300, 0, 1, 2047", items_sent);
        $display("status counts ok %0d size %0d pool %0d free %0d run %0d rec %0d nf %0d",
                 status_seen[cba_pkg::ST_OK], status_seen[cba_pkg::ST_BAD_SIZE],
                 status_seen[cba_pkg::ST_ABOVE_POOL], status_seen[cba_pkg::ST_ABOVE_FREE],
                 status_seen[cba_pkg::ST_NO_RUN], status_seen[cba_pkg::ST_NO_RECORD],
                 status_seen[cba_pkg::ST_NOT_FOUND]);
        if (fail_count == 0 && pending == 0)
            $display("contiguous_block_allocator regression: pass");
        else
            $display("contiguous_block_allocator regression: fail");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("contiguous_block_allocator regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
